// ===== sv/pep_pkg.sv =====
// Shared types and constants for the pendulum Euler propagator.
// No dependencies.
`timescale 1ns / 1ps
package pep_pkg;

  localparam logic signed [35:0] Q28TwoPi = 36'sd1686629713;
  localparam logic signed [35:0] Q28Pi = 36'sd843314857;
  localparam logic signed [35:0] Q28HalfPi = 36'sd421657428;
  localparam logic signed [35:0] CordicGain = 36'sh026DD3B6A;

  localparam logic [1:0] RegGravity = 2'd0;
  localparam logic [1:0] RegInertia = 2'd1;
  localparam logic [1:0] RegDt = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTRL,
    ST_ANGLE,
    ST_ANGLE_WB,
    ST_REDUCE,
    ST_CORDIC,
    ST_SIN,
    ST_GRAV,
    ST_ACCEL,
    ST_RATE_WB,
    ST_OUT
  } pep_state_e;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_TQ,
    MUL_RATE,
    MUL_SIN,
    MUL_ACCEL
  } pep_mul_sel_e;

  typedef struct packed {
    logic load;
    logic mul_go;
    pep_mul_sel_e mul_sel;
    logic ctrl_wb;
    logic angle_wb;
    logic reduce;
    logic cordic_step;
    logic grav_wb;
    logic rate_wb;
    logic out_load;
  } pep_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic cordic_last;
  } pep_status_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'h3243F6A8; 5'd1: t = 32'h1DAC6705; 5'd2: t = 32'h0FADBAFC;
      5'd3: t = 32'h07F56EA6; 5'd4: t = 32'h03FEAB76; 5'd5: t = 32'h01FFD55B;
      5'd6: t = 32'h00FFFAAA; 5'd7: t = 32'h007FFF55; 5'd8: t = 32'h003FFFEA;
      5'd9: t = 32'h001FFFFD; 5'd10: t = 32'h000FFFFF; 5'd11: t = 32'h0007FFFF;
      5'd12: t = 32'h0003FFFF; 5'd13: t = 32'h0001FFFF; 5'd14: t = 32'h0000FFFF;
      5'd15: t = 32'h00007FFF; 5'd16: t = 32'h00003FFF; 5'd17: t = 32'h00001FFF;
      5'd18: t = 32'h00000FFF; 5'd19: t = 32'h000007FF; 5'd20: t = 32'h000003FF;
      5'd21: t = 32'h000001FF; 5'd22: t = 32'h000000FF; 5'd23: t = 32'h0000007F;
      5'd24: t = 32'h0000003F; 5'd25: t = 32'h0000001F; 5'd26: t = 32'h0000000F;
      5'd27: t = 32'h00000008; 5'd28: t = 32'h00000004; 5'd29: t = 32'h00000002;
      5'd30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/pendulum_euler_propagator.sv =====
// Top level: pendulum semi-implicit Euler propagator.
// Depends on pep_pkg, pep_ctrl, pep_datapath.
//
// Usage: one input transfer on s_axis carries start angle, rate, torque and
// a substep count; one output transfer on m_axis returns end angle, end rate
// and a saturation flag. Registers are written through the APB port; the user
// must write them only while the block is idle, which the block does not enforce.
// Processing: per item the shared multiplier scales the torque once, then each
// of N substeps (N the substep count clipped to MAX_SUBSTEPS) runs a rate
// product, a reduction, a CORDIC pass, a sine product and an acceleration
// product. One item is in flight at a time; s_axis_tready is high only while
// the controller is idle, so the next item is accepted only once the last one
// has left the controller.
// The result sits in an output register; the next item is accepted while it
// waits for m_axis_tready, but its result is held until that slot drains.
// Reset clears the controller, the output valid and restores the register
// defaults.
`timescale 1ns / 1ps
module pendulum_euler_propagator
  import pep_pkg::*;
#(
  parameter int unsigned MAX_SUBSTEPS = 2048,
  parameter int unsigned CORDIC_ITERATIONS = 28
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] start_angle, [63:32] start_rate, [95:64] torque,
  // [107:96] substep_count, [111:108] zero
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] end_angle, [63:32] end_rate
  output logic [63:0]  m_axis_tdata,
  // [0] saturated
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [30:0] grav_q, inert_q;
  logic [31:0] dt_q;
  logic        wr;
  pep_cmd_t    cmd;
  pep_status_t st;
  logic        idle, start;
  logic        ovalid_q;
  logic [63:0] odata_q;
  logic        osat_q;
  logic [31:0] ang, rt;
  logic        satf;
  logic        out_free;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= 31'd877783941;
      inert_q <= 31'd14913081;
      dt_q <= 32'd1073742;
    end else if (wr) begin
      if (paddr[3:2] == RegGravity) grav_q <= pwdata[30:0];
      if (paddr[3:2] == RegInertia) inert_q <= pwdata[30:0];
      if (paddr[3:2] == RegDt) dt_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3:2] == RegGravity) prdata = {1'b0, grav_q};
    else if (paddr[3:2] == RegInertia) prdata = {1'b0, inert_q};
    else if (paddr[3:2] == RegDt) prdata = dt_q;
  end

  assign s_axis_tready = idle;
  assign start = s_axis_tvalid && idle;
  assign out_free = !ovalid_q || m_axis_tready;

  pep_ctrl #(.MaxSubsteps(MAX_SUBSTEPS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .count_i    (s_axis_tdata[107:96]),
    .out_free_i (out_free),
    .status_i   (st),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  pep_datapath #(.CordicIterations(CORDIC_ITERATIONS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (st),
    .angle_i   (s_axis_tdata[31:0]),
    .rate_i    (s_axis_tdata[63:32]),
    .torque_i  (s_axis_tdata[95:64]),
    .grav_i    (grav_q),
    .inertia_i (inert_q),
    .dt_i      (dt_q),
    .angle_o   (ang),
    .rate_o    (rt),
    .sat_o     (satf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      odata_q <= {rt, ang};
      osat_q <= satf;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
  assign m_axis_tuser = osat_q;

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  ap_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("second item accepted while busy");
  ap_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> out_free)
    else $error("result overwrote pending output");

endmodule

// ===== sv/pep_mul.sv =====
// Sequential signed-by-unsigned multiply with round-to-nearest scale-down.
// Four 32x16 partial products, one per cycle. Depends on pep_pkg.
`timescale 1ns / 1ps
module pep_mul
  import pep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [63:0] a_i,
  input  logic [31:0]        b_i,
  input  logic [5:0]         shift_i,
  output logic               done_o,
  output logic signed [63:0] p_o
);

  logic        busy_q, busy_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        fin_q;
  logic        neg_q;
  logic [63:0] mag_q;
  logic [31:0] b_q;
  logic [5:0]  sh_q;
  logic [95:0] acc_q, acc_d;
  logic [63:0] mag_d;
  logic [47:0] pp;
  logic [95:0] pp_ext, rnd, scaled;

  assign mag_d = a_i[63] ? 64'(-a_i) : a_i;
  assign pp = {16'd0, b_q} * {32'd0, mag_q[cnt_q*16 +: 16]};
  assign pp_ext = 96'(pp) << (cnt_q * 16);
  assign acc_d = acc_q + pp_ext;
  assign rnd = acc_q + (96'd1 << (sh_q - 6'd1));
  assign scaled = rnd >> sh_q;
  assign p_o = neg_q ? -$signed(scaled[63:0]) : $signed(scaled[63:0]);

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d = 2'd0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 2'd0;
      fin_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      fin_q <= busy_q && (cnt_q == 2'd3) && !go_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      neg_q <= a_i[63];
      mag_q <= mag_d;
      b_q <= b_i;
      sh_q <= shift_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  // result valid the cycle after the last partial product is summed
  assign done_o = fin_q;

endmodule

// ===== sv/pep_datapath.sv =====
// Datapath: state registers, shared multiplier, CORDIC, saturation.
// Depends on pep_pkg and pep_mul.
`timescale 1ns / 1ps
module pep_datapath
  import pep_pkg::*;
#(
  parameter int unsigned CordicIterations = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pep_cmd_t            cmd_i,
  output pep_status_t         status_o,
  input  logic [31:0]         angle_i,
  input  logic [31:0]         rate_i,
  input  logic [31:0]         torque_i,
  input  logic [30:0]         grav_i,
  input  logic [30:0]         inertia_i,
  input  logic [31:0]         dt_i,
  output logic [31:0]         angle_o,
  output logic [31:0]         rate_o,
  output logic                sat_o
);

  logic signed [63:0] angle_q, rate_q, ctrl_q, gs_q;
  logic               sat_q;
  logic signed [35:0] x_q, y_q, z_q;
  logic [4:0]         it_q;
  logic signed [63:0] mul_a, mul_p;
  logic [31:0]        mul_b;
  logic [5:0]         mul_s;
  logic               mul_done;
  logic signed [63:0] asum, rsum, sinv;
  logic signed [35:0] ra, rb, xs, ys;
  logic signed [35:0] ymag, yrnd;
  logic [31:0]        at;

  pep_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (cmd_i.mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .shift_i (mul_s),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // Q2.30 to Q4.28, ties away from zero
  assign ymag = y_q[35] ? -y_q : y_q;
  assign yrnd = (ymag + 36'sd2) >>> 2;
  assign sinv = y_q[35] ? -64'(yrnd) : 64'(yrnd);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_TQ: begin
        mul_a = ctrl_q; mul_b = 32'(inertia_i); mul_s = 6'd26;
      end
      MUL_RATE: begin
        mul_a = rate_q; mul_b = dt_i; mul_s = 6'd32;
      end
      MUL_SIN: begin
        mul_a = sinv; mul_b = 32'(grav_i); mul_s = 6'd28;
      end
      default: begin
        mul_a = gs_q + ctrl_q; mul_b = dt_i; mul_s = 6'd32;
      end
    endcase
  end

  assign asum = angle_q + mul_p;
  assign rsum = rate_q + mul_p;

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic ovf(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  always_comb begin
    ra = 36'(angle_q);
    if (ra > Q28Pi) ra = ra - Q28TwoPi;
    else if (ra < -Q28Pi) ra = ra + Q28TwoPi;
    rb = ra;
    if (ra > Q28HalfPi) rb = Q28Pi - ra;
    else if (ra < -Q28HalfPi) rb = -Q28Pi - ra;
  end

  assign at = atan_q30(it_q);
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      angle_q <= 64'($signed(angle_i));
      rate_q  <= 64'($signed(rate_i));
      ctrl_q  <= 64'($signed(torque_i));
    end
    if (cmd_i.ctrl_wb) ctrl_q <= mul_p;
    if (cmd_i.angle_wb) angle_q <= sat(asum);
    if (cmd_i.rate_wb) rate_q <= sat(rsum);
    if (cmd_i.grav_wb) gs_q <= mul_p;
    if (cmd_i.reduce) begin
      x_q <= CordicGain;
      y_q <= '0;
      z_q <= rb <<< 2;
      it_q <= '0;
    end else if (cmd_i.cordic_step) begin
      if (!z_q[35]) begin
        x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - 36'(at);
      end else begin
        x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + 36'(at);
      end
      it_q <= it_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.load) begin
      sat_q <= 1'b0;
    end else if (cmd_i.angle_wb && ovf(asum)) begin
      sat_q <= 1'b1;
    end else if (cmd_i.rate_wb && ovf(rsum)) begin
      sat_q <= 1'b1;
    end
  end

  assign status_o.mul_done = mul_done;
  assign status_o.cordic_last = (32'(it_q) == CordicIterations - 1);
  assign angle_o = angle_q[31:0];
  assign rate_o = rate_q[31:0];
  assign sat_o = sat_q;

endmodule

// ===== sv/pep_ctrl.sv =====
// Controller FSM sequencing substeps over the datapath.
// Depends on pep_pkg.
`timescale 1ns / 1ps
module pep_ctrl
  import pep_pkg::*;
#(
  parameter int unsigned MaxSubsteps = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [11:0] count_i,
  input  logic        out_free_i,
  input  pep_status_t status_i,
  output pep_cmd_t    cmd_o,
  output logic        idle_o
);

  localparam int unsigned CntW = $clog2(MaxSubsteps + 1) + 1;

  pep_state_e state_q, state_d;
  logic [CntW-1:0] left_q, left_d;
  logic [CntW-1:0] cnt_in;
  logic go_ctrl_q;

  always_comb begin
    cnt_in = CntW'(count_i);
    if (32'(count_i) > MaxSubsteps) cnt_in = CntW'(MaxSubsteps);
  end

  always_comb begin
    state_d = state_q;
    left_d = left_q;
    unique case (state_q)
      ST_IDLE: if (start_i) begin
        state_d = ST_CTRL; left_d = cnt_in;
      end
      ST_CTRL: if (status_i.mul_done) begin
        state_d = (left_q == '0) ? ST_OUT : ST_ANGLE;
      end
      ST_ANGLE: state_d = ST_ANGLE_WB;
      ST_ANGLE_WB: if (status_i.mul_done) state_d = ST_REDUCE;
      ST_REDUCE: state_d = ST_CORDIC;
      ST_CORDIC: if (status_i.cordic_last) state_d = ST_SIN;
      ST_SIN: state_d = ST_GRAV;
      ST_GRAV: if (status_i.mul_done) state_d = ST_ACCEL;
      ST_ACCEL: state_d = ST_RATE_WB;
      ST_RATE_WB: if (status_i.mul_done) begin
        left_d = left_q - CntW'(1);
        state_d = (left_q == CntW'(1)) ? ST_OUT : ST_ANGLE;
      end
      ST_OUT: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = MUL_TQ;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i; cmd_o.mul_go = 1'b0;
      end
      ST_CTRL: begin
        cmd_o.mul_sel = MUL_TQ;
        cmd_o.mul_go = go_ctrl_q;
        cmd_o.ctrl_wb = status_i.mul_done;
      end
      ST_ANGLE: begin
        cmd_o.mul_sel = MUL_RATE; cmd_o.mul_go = 1'b1;
      end
      ST_ANGLE_WB: cmd_o.angle_wb = status_i.mul_done;
      ST_REDUCE: cmd_o.reduce = 1'b1;
      ST_CORDIC: cmd_o.cordic_step = 1'b1;
      ST_SIN: begin
        cmd_o.mul_sel = MUL_SIN; cmd_o.mul_go = 1'b1;
      end
      ST_GRAV: cmd_o.grav_wb = status_i.mul_done;
      ST_ACCEL: begin
        cmd_o.mul_sel = MUL_ACCEL; cmd_o.mul_go = 1'b1;
      end
      ST_RATE_WB: cmd_o.rate_wb = status_i.mul_done;
      ST_OUT: cmd_o.out_load = out_free_i;
      default: cmd_o = '0;
    endcase
  end

  // torque product launches on the first cycle after the accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      left_q <= '0;
      go_ctrl_q <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q <= left_d;
      go_ctrl_q <= (state_q == ST_IDLE) && start_i;
    end
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule
